// File: rtl/bfq_pkg.sv
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared types and constants of the Bloom filter insert/query block.
// ----------------------------------------------------------------------------
package bfq_pkg;

    localparam int MAX_BITS    = 65536;
    localparam int MAX_HASHES  = 30;
    localparam int WORD_W      = 64;
    localparam int STORE_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int POS_W       = $clog2(MAX_BITS) + 1;
    localparam int K_W         = 5;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam logic [63:0] H2_FALLBACK = 64'h9E3779B97F4A7C15;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic {
        REG_NUM_HASHES  = 1'b0,
        REG_FILTER_BITS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MOD_START,
        ST_MOD,
        ST_PROBE_INIT,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  accept_byte;
        logic  hash_clear;
        logic  mod_start;
        logic  probe_init;
        logic  probe_read;
        logic  probe_check;
        logic  sweep_init;
        logic  sweep_write;
        logic  out_load;
        kind_t op_kind;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic sweep_end;
        logic probe_end;
        logic out_free;
    } status_t;

endpackage

// File: rtl/bfq_ram.sv
// ----------------------------------------------------------------------------
// bfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/bfq_mod.sv
// ----------------------------------------------------------------------------
// bfq_mod
// Bit-serial remainder unit: three 64-bit dividends reduced by one modulus,
// one dividend bit per cycle in each lane.
// ----------------------------------------------------------------------------
module bfq_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [63:0]               a,
    input  logic [63:0]               b,
    input  logic [bfq_pkg::POS_W-1:0] n,
    output logic [bfq_pkg::POS_W-1:0] rem_a,
    output logic [bfq_pkg::POS_W-1:0] rem_b,
    output logic [bfq_pkg::POS_W-1:0] rem_ones,
    output logic                      done
);
    import bfq_pkg::*;

    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [63:0]       a_reg, a_next, b_reg, b_next;
    logic [POS_W-1:0]  ra_reg, ra_next, rb_reg, rb_next, ro_reg, ro_next;

    function automatic logic [POS_W-1:0] step(input logic [POS_W-1:0] r,
                                              input logic bit_in,
                                              input logic [POS_W-1:0] m);
        logic [POS_W:0] sh;
        sh = {r, bit_in};
        if (sh >= {1'b0, m})
        begin
            sh = sh - {1'b0, m};
        end
        return sh[POS_W-1:0];
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        ro_next   = ro_reg;
        done      = busy_reg && (cnt_reg == 6'd63);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            ra_next   = '0;
            rb_next   = '0;
            ro_next   = '0;
        end
        else if (busy_reg)
        begin
            ra_next  = step(ra_reg, a_reg[63], n);
            rb_next  = step(rb_reg, b_reg[63], n);
            ro_next  = step(ro_reg, 1'b1, n);
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {b_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        ro_reg <= ro_next;
    end

    assign rem_a    = ra_reg;
    assign rem_b    = rb_reg;
    assign rem_ones = ro_reg;

endmodule

// File: rtl/bfq_datapath.sv
// ----------------------------------------------------------------------------
// bfq_datapath
// Hash, probe position walk, bit store and result register.
// ----------------------------------------------------------------------------
module bfq_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bfq_pkg::cmd_t            cmd,
    output bfq_pkg::status_t         status,
    input  logic [7:0]               key_byte,
    input  logic                     key_last,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [16:0]              cfg_wdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata
);
    import bfq_pkg::*;

    logic [K_W-1:0]   num_hashes_reg;
    logic [16:0]      filter_bits_reg;
    logic [K_W-1:0]   k_eff;
    logic [POS_W-1:0] n_eff;

    logic [63:0]      hash_reg, hash_next, hash_x;
    logic [63:0]      h1_reg, h2_reg, h2_rot;
    logic [63:0]      sum_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [K_W-1:0]   cnt_reg;
    logic             all_set_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic             out_mp_reg;

    logic [POS_W-1:0] rem_h1, rem_h2, rem_ones, wrap_c;
    logic [POS_W:0]   wrap_inc;
    logic [64:0]      sum_ext;
    logic [POS_W:0]   t1;
    logic [POS_W-1:0] t1r;

    logic             ram_we;
    logic [ADDR_W-1:0] ram_wa, ram_ra;
    logic [63:0]      ram_wd, ram_rd, mask;

    // Clamp the configuration to its meaningful range.
    always_comb
    begin
        k_eff = num_hashes_reg;
        if (num_hashes_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (num_hashes_reg > K_W'(MAX_HASHES))
        begin
            k_eff = K_W'(MAX_HASHES);
        end
        n_eff = POS_W'(filter_bits_reg);
        if (filter_bits_reg < 17'd64)
        begin
            n_eff = POS_W'(64);
        end
        else if ({1'b0, filter_bits_reg} > (POS_W + 1)'(MAX_BITS))
        begin
            n_eff = POS_W'(MAX_BITS);
        end
    end

    // FNV-1a step; the prime is 2^40 + 0x1b3.
    assign hash_x    = hash_reg ^ {56'd0, key_byte};
    assign hash_next = {hash_x[23:0], 40'd0} + (hash_x * {55'd0, FNV_PRIME_LO});
    assign h2_rot    = {hash_next[32:0], hash_next[63:33]};

    bfq_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .a        (h1_reg),
        .b        (h2_reg),
        .n        (n_eff),
        .rem_a    (rem_h1),
        .rem_b    (rem_h2),
        .rem_ones (rem_ones),
        .done     (status.mod_done)
    );

    // 2^64 mod n, used when the 64-bit probe sum wraps.
    assign wrap_inc = {1'b0, rem_ones} + (POS_W + 1)'(1);
    assign wrap_c   = (wrap_inc == {1'b0, n_eff}) ? '0 : wrap_inc[POS_W-1:0];

    assign sum_ext = {1'b0, sum_reg} + {1'b0, h2_reg};
    assign t1      = {1'b0, pos_reg} + {1'b0, rem_h2};
    assign t1r     = (t1 >= {1'b0, n_eff}) ? POS_W'(t1 - {1'b0, n_eff}) : t1[POS_W-1:0];

    always_comb
    begin
        pos_next = t1r;
        if (sum_ext[64])
        begin
            if (t1r >= wrap_c)
            begin
                pos_next = t1r - wrap_c;
            end
            else
            begin
                pos_next = t1r + n_eff - wrap_c;
            end
        end
    end

    assign mask   = 64'd1 << pos_reg[5:0];
    assign ram_ra = pos_reg[ADDR_W+5:6];

    always_comb
    begin
        ram_we = 1'b0;
        ram_wa = ram_ra;
        ram_wd = ram_rd | mask;
        if (cmd.sweep_write)
        begin
            ram_we = 1'b1;
            ram_wa = sweep_reg;
            ram_wd = '0;
        end
        else if (cmd.probe_check && (cmd.op_kind == KIND_INSERT))
        begin
            ram_we = 1'b1;
        end
    end

    bfq_ram #(
        .WIDTH (64),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign status.sweep_end = (sweep_reg == ADDR_W'(STORE_WORDS - 1));
    assign status.probe_end = (cnt_reg == k_eff - K_W'(1));
    assign status.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg  <= K_W'(6);
            filter_bits_reg <= 17'(MAX_BITS);
            hash_reg        <= FNV_BASIS;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_NUM_HASHES:  num_hashes_reg  <= cfg_wdata[K_W-1:0];
                    REG_FILTER_BITS: filter_bits_reg <= cfg_wdata;
                    default:         num_hashes_reg  <= num_hashes_reg;
                endcase
            end
            if (cmd.hash_clear || (cmd.accept_byte && key_last))
            begin
                hash_reg <= FNV_BASIS;
            end
            else if (cmd.accept_byte)
            begin
                hash_reg <= hash_next;
            end
            if (cmd.sweep_init)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_write)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_byte && key_last)
        begin
            h1_reg <= hash_next;
            h2_reg <= (h2_rot == '0) ? H2_FALLBACK : h2_rot;
        end
        if (cmd.probe_init)
        begin
            pos_reg     <= rem_h1;
            sum_reg     <= h1_reg;
            cnt_reg     <= '0;
            all_set_reg <= 1'b1;
        end
        else if (cmd.probe_check)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_ext[63:0];
            cnt_reg <= cnt_reg + K_W'(1);
            if (!ram_rd[pos_reg[5:0]])
            begin
                all_set_reg <= 1'b0;
            end
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.op_kind;
            out_mp_reg   <= (cmd.op_kind == KIND_QUERY) && all_set_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_mp_reg, out_kind_reg};

endmodule

// File: rtl/bfq_ctrl.sv
// ----------------------------------------------------------------------------
// bfq_ctrl
// Operation sequencer: input handshake, store sweep, probe walk, result hand-off.
// ----------------------------------------------------------------------------
module bfq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_tuser,
    input  logic             s_tlast,
    input  bfq_pkg::status_t status,
    output bfq_pkg::cmd_t    cmd
);
    import bfq_pkg::*;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   report_reg, report_next;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        report_next = report_reg;
        cmd         = '0;
        cmd.op_kind = kind_reg;
        s_tready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_end)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (kind_t'(s_tuser))
                        KIND_INSERT, KIND_QUERY:
                        begin
                            cmd.accept_byte = 1'b1;
                            if (s_tlast)
                            begin
                                kind_next  = kind_t'(s_tuser);
                                state_next = ST_MOD_START;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cmd.hash_clear = 1'b1;
                            cmd.sweep_init = 1'b1;
                            kind_next      = KIND_CLEAR;
                            report_next    = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MOD_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_PROBE_INIT;
                end
            end
            ST_PROBE_INIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = ST_PROBE_RD;
            end
            ST_PROBE_RD:
            begin
                cmd.probe_read = 1'b1;
                state_next     = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                cmd.probe_check = 1'b1;
                state_next      = status.probe_end ? ST_DONE : ST_PROBE_RD;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            kind_reg   <= KIND_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            report_reg <= report_next;
        end
    end

endmodule

// File: rtl/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter over byte-stream keys with insert, query and clear.
// ----------------------------------------------------------------------------
// Key bytes are hashed with 64-bit FNV-1a at one byte per cycle while the block
// is idle; a byte that does not end a key gives no result. On the last byte the
// block computes h1 mod n, h2 mod n and 2^64 mod n in a bit-serial remainder
// unit, then walks the k probe positions, reading one 64-bit store word per
// probe and, for an insert, writing it back with the probe bit set, and hands
// one result to the output register once that register is free. A clear
// transaction, and reset, zero the 1024-word store one word per cycle, during
// which no input is taken; configuration writes are taken at any time but must
// be made while the block is idle. An insert or clear result reports
// maybe_present as 0.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] key_byte
    input  logic [1:0]  s_tuser,    // [1:0] kind
    input  logic        s_tlast,    // key_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [1:0] done_kind, [2] maybe_present, [7:3] zero
    input  logic        cfg_we,
    input  logic        cfg_index,  // 0 num_hashes, 1 filter_bits
    input  logic [16:0] cfg_wdata
);
    import bfq_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer owns the input handshake and issues one command set per cycle.
    bfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath holds the hash, the probe walk, the store and the result.
    bfq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key_byte  (s_tdata),
        .key_last  (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
